// ----- rtl/bfgb_pkg.sv -----
`default_nettype none
package bfgb_pkg;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DRAW   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_COLOUR = 2'd0;
  localparam logic [1:0] REG_STRIDE = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_GBYTES = 2'd3;

  // Register reset values.
  localparam logic [31:0] COLOUR_RESET = 32'hFFFF_FFFF;
  localparam logic [13:0] STRIDE_RESET = 14'd1024;
  localparam logic [13:0] WIDTH_RESET  = 14'd1024;
  localparam logic [5:0]  GBYTES_RESET = 6'd16;

  // Text layout constants.
  localparam int unsigned GLYPH_COLUMNS = 8;
  localparam logic [12:0] MARGIN        = 13'd24;
  localparam logic [12:0] LINE_HEIGHT   = 13'd16;
  localparam logic [12:0] CURSOR_MAX    = 13'd8191;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;
    logic set_cursor;
    logic capture;
    logic prep;
    logic run;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_last;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/bfgb_regs.sv -----
`default_nettype none
module bfgb_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [31:0] draw_colour,
  output logic      [13:0] line_stride,
  output logic      [13:0] line_width,
  output logic      [5:0]  glyph_bytes
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_colour <= bfgb_pkg::COLOUR_RESET;
      line_stride <= bfgb_pkg::STRIDE_RESET;
      line_width  <= bfgb_pkg::WIDTH_RESET;
      glyph_bytes <= bfgb_pkg::GBYTES_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        bfgb_pkg::REG_COLOUR: draw_colour <= pwdata;
        bfgb_pkg::REG_STRIDE: line_stride <= pwdata[13:0];
        bfgb_pkg::REG_WIDTH:  line_width  <= pwdata[13:0];
        bfgb_pkg::REG_GBYTES: glyph_bytes <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_sel)
      bfgb_pkg::REG_COLOUR: prdata = draw_colour;
      bfgb_pkg::REG_STRIDE: prdata = {18'd0, line_stride};
      bfgb_pkg::REG_WIDTH:  prdata = {18'd0, line_width};
      bfgb_pkg::REG_GBYTES: prdata = {26'd0, glyph_bytes};
      default:              prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/bfgb_ctrl.sv -----
`default_nettype none
module bfgb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     op,
  input  bfgb_pkg::sts_t      sts,
  output bfgb_pkg::cmd_t      cmd,
  output logic                busy
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Next-state logic: a draw goes through the setup state ST_PREP and then ST_RUN until the last row.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (op == bfgb_pkg::OP_DRAW)) state_next = ST_PREP;
      end
      ST_PREP: state_next = ST_RUN;
      ST_RUN: begin
        if (sts.row_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.load_we    = accept && (op == bfgb_pkg::OP_LOAD);
    cmd.set_cursor = accept && (op == bfgb_pkg::OP_CURSOR);
    cmd.capture    = accept && (op == bfgb_pkg::OP_DRAW);
    cmd.prep       = (state == ST_PREP);
    cmd.run        = (state == ST_RUN);
  end

  // The last row always returns the controller to idle.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && sts.row_last) |=> (state == ST_IDLE))
    else $error("draw did not finish after last row");

  // A captured draw is always followed by the setup state.
  a_capture_prep: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_PREP))
    else $error("draw capture not followed by setup");

endmodule
`default_nettype wire

// ----- rtl/bfgb_datapath.sv -----
`default_nettype none
module bfgb_datapath #(
  parameter int FONT_STORE_BYTES = 8192,
  parameter int GLYPH_ROWS       = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  bfgb_pkg::cmd_t      cmd,
  output bfgb_pkg::sts_t      sts,
  input  wire logic [12:0]    font_addr,
  input  wire logic [7:0]     font_byte,
  input  wire logic [7:0]     char_code,
  input  wire logic [12:0]    new_cursor_x,
  input  wire logic [12:0]    new_cursor_y,
  input  wire logic [31:0]    draw_colour,
  input  wire logic [13:0]    line_stride,
  input  wire logic [13:0]    line_width,
  input  wire logic [5:0]     glyph_bytes,
  output logic      [25:0]    pixel_index,
  output logic      [7:0]     pixel_mask,
  output logic      [31:0]    pixel_colour,
  output logic                last_row,
  output logic                result_valid
);

  // Addresses wrap by truncation; user must keep FONT_STORE_BYTES 2**n (unchecked).
  localparam int AW = $clog2(FONT_STORE_BYTES);
  localparam int RW = $clog2(GLYPH_ROWS);
  localparam logic [RW-1:0] ROW_LAST = RW'(GLYPH_ROWS - 1);

  logic [7:0]    glyph_mem [FONT_STORE_BYTES];
  logic [7:0]    glyph_mem_q;
  logic [7:0]    char_reg;
  logic [13:0]   base;
  logic [RW-1:0] row;
  logic [25:0]   idx_acc;
  logic [12:0]   cursor_x;
  logic [12:0]   cursor_y;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [26:0]   y_times_stride;
  logic [13:0]   nx;
  logic [13:0]   limit;
  logic [14:0]   nx_end;
  logic [13:0]   ny;
  logic          wrap;

  assign sts.row_last = (row == ROW_LAST);
  assign wr_addr      = AW'(font_addr);
  assign rd_addr      = AW'({1'b0, base} + {{(15 - RW){1'b0}}, row});
  assign pixel_mask   = glyph_mem_q;
  assign pixel_colour = draw_colour;

  // Glyph store: one write port for loads, one registered read per row.
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      glyph_mem[wr_addr] <= font_byte;
    end
    if (cmd.run) begin
      glyph_mem_q <= glyph_mem[rd_addr];
    end
  end

  // Character capture, glyph base, and the pixel index: first row, then one stride per row.
  assign y_times_stride = {14'd0, cursor_y} * {13'd0, line_stride};
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_reg <= char_code;
    end
    if (cmd.prep) begin
      base    <= {6'd0, char_reg} * {8'd0, glyph_bytes};
      idx_acc <= 26'({14'd0, cursor_x} + y_times_stride);
    end else if (cmd.run) begin
      idx_acc <= 26'(idx_acc + {12'd0, line_stride});
    end
  end

  // Row counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (cmd.prep) begin
      row <= '0;
    end else if (cmd.run) begin
      row <= RW'(row + 1'b1);
    end
  end

  // Cursor placement on set-cursor items, and advance with line wrap on the last row.
  assign nx     = {1'b0, cursor_x} + 14'(bfgb_pkg::GLYPH_COLUMNS);
  assign limit  = (line_width >= {1'b0, bfgb_pkg::MARGIN}) ?
                  (line_width - {1'b0, bfgb_pkg::MARGIN}) : 14'd0;
  assign nx_end = {1'b0, nx} + 15'(bfgb_pkg::GLYPH_COLUMNS);
  assign wrap   = (nx_end > {1'b0, limit}) || nx[13];
  assign ny     = {1'b0, cursor_y} + {1'b0, bfgb_pkg::LINE_HEIGHT};

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= bfgb_pkg::MARGIN;
      cursor_y <= bfgb_pkg::MARGIN;
    end else if (cmd.set_cursor) begin
      cursor_x <= new_cursor_x;
      cursor_y <= new_cursor_y;
    end else if (cmd.run && sts.row_last) begin
      if (wrap) begin
        cursor_x <= bfgb_pkg::MARGIN;
        cursor_y <= ny[13] ? bfgb_pkg::CURSOR_MAX : ny[12:0];
      end else begin
        cursor_x <= nx[12:0];
      end
    end
  end

  // Result registers, aligned with the registered glyph read.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.run;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      pixel_index <= idx_acc;
      last_row    <= sts.row_last;
    end
  end

  // A result appears only in the cycle after a row read.
  a_valid_follows_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.run))
    else $error("result strobe without a row read");

  // Consecutive rows of one character step by one scan line.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(result_valid) && !$past(last_row)) |->
      (pixel_index == 26'($past(pixel_index) + {12'd0, line_stride})))
    else $error("row index did not advance by the stride");

  // The result strobe for the final row is never directly followed by another strobe.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_row) |=> !result_valid)
    else $error("result strobe right after the last row");

endmodule
`default_nettype wire

// ----- rtl/bitmap_font_glyph_blitter_unit.sv -----
`default_nettype none
// Bitmap font text renderer. Load items (op 0) write one byte of the glyph store
// and set-cursor items (op 2) place the text cursor; both take effect at the
// accepting edge, produce no result and leave busy low. A draw item (op 1) keeps
// busy high through a setup state, which forms the glyph base address and the
// first pixel index, and a row state, in which the glyph store (one write port,
// one read port) is read one row per cycle. Results are registered and appear in
// the cycle after each row read, each shown for exactly one cycle with
// result_valid high; no new item is accepted until busy falls again. The
// receiver cannot stall the block and must take every strobed result. An
// op value of 3 is accepted and ignored. FONT_STORE_BYTES must be a power of two.
module bitmap_font_glyph_blitter_unit #(
  parameter int FONT_STORE_BYTES = 8192,
  parameter int GLYPH_ROWS       = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [12:0] font_addr,
  input  wire logic [7:0]  font_byte,
  input  wire logic [7:0]  char_code,
  input  wire logic [12:0] new_cursor_x,
  input  wire logic [12:0] new_cursor_y,
  output logic             result_valid,
  output logic      [25:0] pixel_index,
  output logic      [7:0]  pixel_mask,
  output logic      [31:0] pixel_colour,
  output logic             last_row,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  bfgb_pkg::cmd_t cmd;
  bfgb_pkg::sts_t sts;
  logic [31:0]    draw_colour;
  logic [13:0]    line_stride;
  logic [13:0]    line_width;
  logic [5:0]     glyph_bytes;

  bfgb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .draw_colour (draw_colour),
    .line_stride (line_stride),
    .line_width  (line_width),
    .glyph_bytes (glyph_bytes)
  );

  bfgb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bfgb_datapath #(
    .FONT_STORE_BYTES (FONT_STORE_BYTES),
    .GLYPH_ROWS       (GLYPH_ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .font_addr    (font_addr),
    .font_byte    (font_byte),
    .char_code    (char_code),
    .new_cursor_x (new_cursor_x),
    .new_cursor_y (new_cursor_y),
    .draw_colour  (draw_colour),
    .line_stride  (line_stride),
    .line_width   (line_width),
    .glyph_bytes  (glyph_bytes),
    .pixel_index  (pixel_index),
    .pixel_mask   (pixel_mask),
    .pixel_colour (pixel_colour),
    .last_row     (last_row),
    .result_valid (result_valid)
  );

endmodule
`default_nettype wire

// ----- verif/blitter_row_checker.sv -----
`timescale 1ns / 100ps
module blitter_row_checker
  import bfgb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  op,
  input  wire logic [12:0] font_addr,
  input  wire logic [7:0]  font_byte,
  input  wire logic [7:0]  char_code,
  input  wire logic [12:0] new_cursor_x,
  input  wire logic [12:0] new_cursor_y,
  input  wire logic        result_valid,
  input  wire logic [25:0] pixel_index,
  input  wire logic [7:0]  pixel_mask,
  input  wire logic [31:0] pixel_colour,
  input  wire logic        last_row,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               rows_pending,
  output int               rows_checked
);

  localparam int ROWS_PER_GLYPH = 16;
  localparam int STORE_BYTES    = 8192;

  // One framebuffer row write as the block should emit it.
  typedef struct packed {
    logic [25:0] spot;
    logic [7:0]  mask;
    logic [31:0] colour;
    logic        last_flag;
  } pixel_row_t;

  pixel_row_t  expected_rows[$];
  logic [7:0]  glyph_mem [STORE_BYTES];
  logic [12:0] cur_x;
  logic [12:0] cur_y;
  logic [31:0] colour_reg;
  logic [13:0] stride_reg;
  logic [13:0] width_reg;
  logic [5:0]  gbytes_reg;

  // Queues the sixteen row writes of one character, then moves the cursor on,
  // dropping to the next text line once the right margin is passed.
  task automatic predict_glyph_rows(input logic [7:0] code);
    int unsigned base;
    int unsigned nx;
    int unsigned ny;
    int unsigned limit;
    longint unsigned offset;
    pixel_row_t row;
    base = 32'(code) * 32'(gbytes_reg);
    for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
      offset = 64'(cur_x) + (64'(cur_y) + 64'(r)) * 64'(stride_reg);
      row.spot = offset[25:0];
      row.mask = glyph_mem[13'((base + r) % STORE_BYTES)];
      row.colour = colour_reg;
      row.last_flag = (r == ROWS_PER_GLYPH - 1);
      expected_rows.push_back(row);
    end
    nx = 32'(cur_x) + GLYPH_COLUMNS;
    limit = (32'(width_reg) >= 32'(MARGIN)) ? 32'(width_reg) - 32'(MARGIN) : 0;
    if (nx + GLYPH_COLUMNS > limit || nx > 32'(CURSOR_MAX)) begin
      ny = 32'(cur_y) + 32'(LINE_HEIGHT);
      cur_x = MARGIN;
      cur_y = (ny > 32'(CURSOR_MAX)) ? CURSOR_MAX : ny[12:0];
    end else begin
      cur_x = nx[12:0];
    end
  endtask

  always @(posedge clk) begin : watch
    pixel_row_t want;
    if (rst) begin
      expected_rows.delete();
      cur_x = MARGIN;
      cur_y = MARGIN;
      colour_reg = COLOUR_RESET;
      stride_reg = STRIDE_RESET;
      width_reg = WIDTH_RESET;
      gbytes_reg = GBYTES_RESET;
      fail_count = 0;
      rows_checked = 0;
    end else begin
      // Results are compared before this edge's item is predicted, since a
      // draw never answers at its own accepting edge.
      if (result_valid) begin
        if (expected_rows.size() == 0) begin
          $error("row write with no draw outstanding: pixel_index %0h", pixel_index);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          rows_checked++;
          if (pixel_index !== want.spot) begin
            $error("pixel_index mismatch: expected %0h, actual %0h", want.spot, pixel_index);
            fail_count++;
          end
          if (pixel_mask !== want.mask) begin
            $error("pixel_mask mismatch: expected %0h, actual %0h", want.mask, pixel_mask);
            fail_count++;
          end
          if (pixel_colour !== want.colour) begin
            $error("pixel_colour mismatch: expected %0h, actual %0h",
                   want.colour, pixel_colour);
            fail_count++;
          end
          if (last_row !== want.last_flag) begin
            $error("last_row mismatch: expected %0b, actual %0b", want.last_flag, last_row);
            fail_count++;
          end
        end
      end

      // Register writes are mirrored at the edge that completes the access.
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_COLOUR: colour_reg = pwdata;
          REG_STRIDE: stride_reg = pwdata[13:0];
          REG_WIDTH:  width_reg = pwdata[13:0];
          REG_GBYTES: gbytes_reg = pwdata[5:0];
          default: ;
        endcase
      end

      // Accepted items update the font copy, the cursor or the expectations.
      if (start && !busy) begin
        case (op_t'(op))
          OP_LOAD:   glyph_mem[font_addr] = font_byte;
          OP_CURSOR: begin
            cur_x = new_cursor_x;
            cur_y = new_cursor_y;
          end
          OP_DRAW:   predict_glyph_rows(char_code);
          default: ;
        endcase
      end
    end
    rows_pending = expected_rows.size();
  end

endmodule

// ----- verif/bitmap_font_glyph_blitter_unit_tb.sv -----
`timescale 1ns / 100ps
module bitmap_font_glyph_blitter_unit_tb;
  import bfgb_pkg::*;

  localparam int STORE_BYTES       = 8192;
  localparam int ROWS_PER_GLYPH    = 16;
  localparam int ITEMS_PER_SETTING = 25;
  localparam int CYCLE_LIMIT       = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op = OP_NONE;
  logic [12:0] font_addr = '0;
  logic [7:0]  font_byte = '0;
  logic [7:0]  char_code = '0;
  logic [12:0] new_cursor_x = '0;
  logic [12:0] new_cursor_y = '0;
  logic        result_valid;
  logic [25:0] pixel_index;
  logic [7:0]  pixel_mask;
  logic [31:0] pixel_colour;
  logic        last_row;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int rows_pending;
  int rows_checked;
  int cycle_count = 0;
  int idle_pct = 0;
  int width_now = int'(WIDTH_RESET);
  int gb_now = int'(GBYTES_RESET);
  int n_sent = 0;
  int n_draws = 0;
  int n_loads = 0;
  int n_cursor = 0;
  int n_ignored = 0;

  // Font bytes written so far; a draw only reads rows that were loaded.
  bit         font_loaded [STORE_BYTES];
  logic [7:0] code_pool [8];
  int         pool_fill = 0;

  bitmap_font_glyph_blitter_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .font_addr(font_addr), .font_byte(font_byte), .char_code(char_code),
    .new_cursor_x(new_cursor_x), .new_cursor_y(new_cursor_y),
    .result_valid(result_valid), .pixel_index(pixel_index), .pixel_mask(pixel_mask),
    .pixel_colour(pixel_colour), .last_row(last_row),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  blitter_row_checker row_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .font_addr(font_addr), .font_byte(font_byte), .char_code(char_code),
    .new_cursor_x(new_cursor_x), .new_cursor_y(new_cursor_y),
    .result_valid(result_valid), .pixel_index(pixel_index), .pixel_mask(pixel_mask),
    .pixel_colour(pixel_colour), .last_row(last_row),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .fail_count(fail_count), .rows_pending(rows_pending), .rows_checked(rows_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d rows outstanding",
               cycle_count, rows_pending);
      $display("status: fail");
      $finish;
    end
  end

  // Presents one item after a random idle gap and holds it until accepted.
  // Start stays high afterwards; it is lowered only in an idle gap or by settle().
  task automatic send_item(input op_t kind, input logic [12:0] addr,
                           input logic [7:0] data, input logic [7:0] code,
                           input logic [12:0] cx, input logic [12:0] cy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= kind;
    font_addr <= addr;
    font_byte <= data;
    char_code <= code;
    new_cursor_x <= cx;
    new_cursor_y <= cy;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  // Stops sending and waits until every expected row has come back.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (rows_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] colour, input int stride,
                               input int width, input int gb);
    settle();
    write_reg(REG_COLOUR, colour);
    write_reg(REG_STRIDE, stride);
    write_reg(REG_WIDTH, width);
    write_reg(REG_GBYTES, gb);
    width_now = width;
    gb_now = gb;
  endtask

  // Glyph row contents lean toward empty, full and single-pixel rows.
  function automatic logic [7:0] glyph_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic load_byte(input logic [12:0] addr, input logic [7:0] data);
    send_item(OP_LOAD, addr, data, 8'($urandom), 13'($urandom), 13'($urandom));
    font_loaded[addr] = 1'b1;
    n_loads++;
  endtask

  // Fills in any glyph row not yet loaded, then draws the character.
  task automatic draw_char(input logic [7:0] code);
    int a;
    for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
      a = (int'(code) * gb_now + r) % STORE_BYTES;
      if (!font_loaded[13'(a)]) load_byte(13'(a), glyph_byte());
    end
    send_item(OP_DRAW, 13'($urandom), 8'($urandom), code, 13'($urandom), 13'($urandom));
    n_draws++;
  endtask

  task automatic place_cursor(input logic [12:0] cx, input logic [12:0] cy);
    send_item(OP_CURSOR, 13'($urandom), 8'($urandom), 8'($urandom), cx, cy);
    n_cursor++;
  endtask

  // Mostly reuses glyphs already in the font, sometimes brings in a new one.
  function automatic logic [7:0] pick_code();
    logic [7:0] code;
    if (pool_fill > 0 && $urandom_range(99) < 85)
      return code_pool[3'($urandom_range(pool_fill - 1))];
    case ($urandom_range(7))
      0: code = 8'd0;
      1: code = 8'd255;
      default: code = 8'($urandom);
    endcase
    if (pool_fill < 8) begin
      code_pool[3'(pool_fill)] = code;
      pool_fill++;
    end else begin
      code_pool[3'($urandom_range(7))] = code;
    end
    return code;
  endfunction

  initial begin : stimulus
    int quota;
    int roll;
    int slot;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset settings: ignored op, cursor extremes,
    // saturation at the bottom, and the exact right-margin boundary.
    send_item(OP_NONE, 13'h1FFF, 8'hFF, 8'hFF, 13'h1FFF, 13'h1FFF);
    n_ignored++;
    place_cursor(13'd0, 13'd0);
    draw_char(8'd0);
    draw_char(8'd0);
    place_cursor(13'd8191, 13'd8191);
    draw_char(8'd0);
    place_cursor(13'd8183, 13'd8180);
    draw_char(8'd0);
    place_cursor(13'd976, 13'd40);
    draw_char(8'd0);
    draw_char(8'd0);
    draw_char(8'd0);
    load_byte(13'd8191, 8'hFF);
    load_byte(13'd0, 8'h5A);
    draw_char(8'd0);

    // Random part over six register settings and three idle patterns.
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: apply_setting(32'hFFFF_FFFF, 1, 32, 16);
        1: apply_setting(32'h0000_0000, 8192, 8192, 32);
        2: apply_setting($urandom, 640, 640, 17);
        3: apply_setting($urandom, 8191, 100, 24);
        4: apply_setting($urandom, $urandom_range(8192, 1), $urandom_range(8192, 32),
                         $urandom_range(32, 16));
        default: apply_setting($urandom, int'(STRIDE_RESET), int'(WIDTH_RESET),
                               int'(GBYTES_RESET));
      endcase
      idle_pct = (s < 2) ? 24 : (s < 4) ? 87 : 0;
      // Every item sent counts toward the share of this setting, glyph loads too.
      quota = n_sent + ITEMS_PER_SETTING;
      while (n_sent < quota) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          draw_char(pick_code());
        end else if (roll < 70) begin
          case ($urandom_range(3))
            0: place_cursor(13'($urandom), 13'($urandom));
            1: place_cursor(13'($urandom_range(width_now)), 13'($urandom_range(400)));
            2: place_cursor($urandom_range(1) ? 13'd8191 : 13'd0,
                            $urandom_range(1) ? 13'd8191 : 13'd8176);
            default: place_cursor(MARGIN, MARGIN);
          endcase
        end else if (roll < 88) begin
          // Half the loads, once the pool holds a code, rewrite a row of a glyph in the code pool.
          if (pool_fill > 0 && $urandom_range(1)) begin
            slot = (int'(code_pool[3'($urandom_range(pool_fill - 1))]) * gb_now
                    + $urandom_range(ROWS_PER_GLYPH - 1)) % STORE_BYTES;
            load_byte(13'(slot), glyph_byte());
          end else begin
            load_byte(13'($urandom), 8'($urandom));
          end
        end else if (roll < 95) begin
          send_item(OP_NONE, 13'($urandom), 8'($urandom), 8'($urandom),
                    13'($urandom), 13'($urandom));
          n_ignored++;
        end else begin
          settle();
        end
      end
    end

    settle();
    repeat (40) @(posedge clk);
    $display("Sent %0d items: %0d draws, %0d font loads, %0d cursor moves, %0d ignored",
             n_draws + n_loads + n_cursor + n_ignored, n_draws, n_loads, n_cursor, n_ignored);
    $display("Compared %0d glyph rows over seven register settings and three idle mixes",
             rows_checked);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
